[hw/rtl/spnd_pkg.sv]
// Shared types, constants and decode helpers for the sync pulse number decoder.
package spnd_pkg;

    localparam int SAMPLES_PER_CHANNEL = 512;
    localparam int FRAME_LEN   = 2 * SAMPLES_PER_CHANNEL;
    localparam int IDX_W       = $clog2(FRAME_LEN);
    localparam int CNT_W       = $clog2(FRAME_LEN + 1);
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;
    localparam int MEM_AW      = IDX_W + QUEUE_AW;

    localparam int WORD_W   = 11;
    localparam int SAMPLE_W = 10;
    localparam int NUM_W    = 16;
    localparam int STAT_W   = 2;
    localparam int RES_W    = 18;
    localparam int CFG_IDX_W = 1;

    localparam int SLICE_LEN  = 60;
    localparam int SLICE_KEEP = 54;
    localparam int SLICE_IW   = $clog2(SLICE_KEEP);
    localparam int SLICE_CW   = $clog2(SLICE_KEEP + 1);

    localparam logic [SAMPLE_W-1:0] MIN_RESET   = SAMPLE_W'(1000);
    localparam logic [SAMPLE_W-1:0] FLOOR_RESET = SAMPLE_W'(50);
    localparam logic [SAMPLE_W-1:0] SWING_RESET = SAMPLE_W'(50);

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING = 1'b1;

    localparam logic [STAT_W-1:0] ST_VALID    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_PULSE = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd2;

    localparam logic signed [RES_W-1:0] RES_NONE   = -18'sd1;
    localparam logic signed [RES_W-1:0] RES_REJECT = -18'sd2;

    localparam logic [5:0] BIT_POS [NUM_W] = '{
        6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd20, 6'd23, 6'd26,
        6'd29, 6'd32, 6'd36, 6'd39, 6'd42, 6'd45, 6'd48, 6'd52
    };

    typedef struct packed {
        logic [WORD_W-1:0] sample_word;
        logic              last_sample;
    } t_in_beat;

    typedef struct packed {
        logic [NUM_W-1:0]  sync_number;
        logic [STAT_W-1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [SAMPLE_W-1:0] max_level;
        logic [SAMPLE_W-1:0] min_level;
        logic [QUEUE_AW-1:0] bank;
    } t_frame_desc;

    typedef struct packed {
        logic                we;
        logic [MEM_AW-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_mem_wr;

    function automatic logic [NUM_W-1:0] pick_bits(input logic [SLICE_KEEP-1:0] slice,
                                                   input int ofs);
        logic [NUM_W-1:0] r;
        for (int j = 0; j < NUM_W; j++) begin
            r[j] = slice[int'(BIT_POS[j]) + ofs];
        end
        return r;
    endfunction

endpackage

[hw/rtl/spnd_ram.sv]
// Simple dual-port sample memory with a registered read port.
module spnd_ram #(
    parameter int AW = 11,
    parameter int DW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2 ** AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/spnd_fifo.sv]
// Short queue of finished frame descriptors between the front and back parts.
module spnd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  spnd_pkg::t_frame_desc i_din,
    input  logic                 i_pop,
    output spnd_pkg::t_frame_desc o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    spnd_pkg::t_frame_desc r_mem [spnd_pkg::QUEUE_DEPTH];
    logic [spnd_pkg::QUEUE_AW-1:0] r_wptr;
    logic [spnd_pkg::QUEUE_AW-1:0] r_rptr;
    logic [spnd_pkg::QUEUE_AW:0]   r_count;
    logic [spnd_pkg::QUEUE_AW:0]   n_count;

    assign o_full  = (r_count == (spnd_pkg::QUEUE_AW + 1)'(spnd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/spnd_front.sv]
// Front part: accepts samples, stores them and tracks the frame's extremes.
module spnd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_stall,
    input  spnd_pkg::t_in_beat            i_in_data,
    input  logic [spnd_pkg::SAMPLE_W-1:0] i_floor,
    output logic                          o_push,
    output spnd_pkg::t_frame_desc         o_desc,
    output spnd_pkg::t_mem_wr             o_mem_wr
);

    logic [spnd_pkg::CNT_W-1:0]    r_cnt;
    logic [spnd_pkg::CNT_W-1:0]    n_cnt;
    logic [spnd_pkg::SAMPLE_W-1:0] r_max;
    logic [spnd_pkg::SAMPLE_W-1:0] n_max;
    logic [spnd_pkg::SAMPLE_W-1:0] r_min;
    logic [spnd_pkg::SAMPLE_W-1:0] n_min;
    logic [spnd_pkg::QUEUE_AW-1:0] r_bank;
    logic                          w_accept;
    logic                          w_room;
    logic [spnd_pkg::SAMPLE_W-1:0] w_value;

    assign w_accept = i_in_valid && !i_stall;
    assign w_room   = (r_cnt < spnd_pkg::CNT_W'(spnd_pkg::FRAME_LEN));
    assign w_value  = i_in_data.sample_word[spnd_pkg::WORD_W-1] ? '0
                    : i_in_data.sample_word[spnd_pkg::SAMPLE_W-1:0];

    always_comb begin
        n_cnt = r_cnt;
        n_max = r_max;
        n_min = r_min;
        if (w_accept && w_room) begin
            n_cnt = r_cnt + 1'b1;
            if (w_value > r_max) begin
                n_max = w_value;
            end
            if (w_value < r_min && w_value > i_floor) begin
                n_min = w_value;
            end
        end
    end

    assign o_mem_wr.we   = w_accept && w_room;
    assign o_mem_wr.addr = {r_bank, r_cnt[spnd_pkg::IDX_W-1:0]};
    assign o_mem_wr.data = w_value;

    assign o_push           = w_accept && i_in_data.last_sample;
    assign o_desc.count     = n_cnt;
    assign o_desc.max_level = n_max;
    assign o_desc.min_level = n_min;
    assign o_desc.bank      = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_max  <= '0;
            r_min  <= spnd_pkg::MIN_RESET;
            r_bank <= '0;
        end else if (w_accept) begin
            if (i_in_data.last_sample) begin
                r_cnt  <= '0;
                r_max  <= '0;
                r_min  <= spnd_pkg::MIN_RESET;
                r_bank <= r_bank + 1'b1;
            end else begin
                r_cnt <= n_cnt;
                r_max <= n_max;
                r_min <= n_min;
            end
        end
    end

endmodule

[hw/rtl/spnd_back.sv]
// Back part: finds the pulse, slices its bits, decodes and checks the number.
module spnd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spnd_pkg::t_frame_desc         i_head,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  logic [spnd_pkg::SAMPLE_W-1:0] i_min_swing,
    output logic [spnd_pkg::MEM_AW-1:0]   o_raddr,
    input  logic [spnd_pkg::SAMPLE_W-1:0] i_rdata,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output spnd_pkg::t_out_beat           o_out_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SLICE  = 3'd3;
    localparam logic [2:0] S_DECODE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [spnd_pkg::CNT_W-1:0]      r_n, n_n;
    logic [spnd_pkg::SAMPLE_W-1:0]   r_thr, n_thr;
    logic [spnd_pkg::SAMPLE_W-1:0]   r_min, n_min;
    logic [spnd_pkg::QUEUE_AW-1:0]   r_bank, n_bank;
    logic [spnd_pkg::CNT_W-1:0]      r_addr, n_addr;
    logic                            r_pend_vld, n_pend_vld;
    logic [spnd_pkg::CNT_W-1:0]      r_pend_idx, n_pend_idx;
    logic [spnd_pkg::CNT_W-1:0]      r_k, n_k;
    logic [spnd_pkg::SLICE_CW-1:0]   r_sidx, n_sidx;
    logic [spnd_pkg::SLICE_KEEP-1:0] r_slice, n_slice;
    logic signed [spnd_pkg::RES_W-1:0] r_res, n_res;
    logic signed [spnd_pkg::RES_W-1:0] r_prev, n_prev;
    logic                            r_out_vld, n_out_vld;
    spnd_pkg::t_out_beat             r_out_data, n_out_data;

    logic                            w_pulse_ok;
    logic signed [spnd_pkg::SAMPLE_W+1:0] w_swing;
    logic [spnd_pkg::NUM_W-1:0]      w_r1;
    logic [spnd_pkg::NUM_W-1:0]      w_r2;
    logic signed [spnd_pkg::RES_W-1:0] w_s1;
    logic signed [spnd_pkg::RES_W-1:0] w_s2;
    logic signed [spnd_pkg::RES_W-1:0] w_chk;

    assign o_raddr     = {r_bank, r_addr[spnd_pkg::IDX_W-1:0]};
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    assign w_swing = $signed({2'b00, r_thr}) - $signed({2'b00, r_min});
    assign w_pulse_ok = (r_k != '0)
        && (({1'b0, r_k} + (spnd_pkg::CNT_W + 1)'(spnd_pkg::SLICE_LEN)) < {1'b0, r_n})
        && (w_swing > $signed({2'b00, i_min_swing}));

    assign w_r1 = spnd_pkg::pick_bits(r_slice, 0);
    assign w_r2 = spnd_pkg::pick_bits(r_slice, 1);
    assign w_s1 = $signed({2'b00, w_r1});
    assign w_s2 = $signed({2'b00, w_r2});

    always_comb begin
        w_chk = w_s2;
        if (w_s1 != w_s2) begin
            if (w_chk < r_prev) begin
                w_chk = w_s1;
            end
            if (w_chk < r_prev) begin
                w_chk = spnd_pkg::RES_REJECT;
            end
        end
        if (r_prev >= 0 && w_chk <= r_prev) begin
            w_chk = spnd_pkg::RES_REJECT;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_thr      = r_thr;
        n_min      = r_min;
        n_bank     = r_bank;
        n_addr     = r_addr;
        n_pend_vld = 1'b0;
        n_pend_idx = r_pend_idx;
        n_k        = r_k;
        n_sidx     = r_sidx;
        n_slice    = r_slice;
        n_res      = r_res;
        n_prev     = r_prev;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_data = r_out_data;
        o_pop      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_n     = i_head.count;
                    n_thr   = spnd_pkg::SAMPLE_W'(({1'b0, i_head.max_level}
                              + {1'b0, i_head.min_level}) >> 1);
                    n_min   = i_head.min_level;
                    n_bank  = i_head.bank;
                    n_addr  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr < r_n) begin
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_addr;
                    n_addr     = r_addr + 1'b1;
                end
                if (r_pend_vld && i_rdata >= r_thr) begin
                    n_k        = r_pend_idx;
                    n_pend_vld = 1'b0;
                    n_state    = S_CHECK;
                end else if (!r_pend_vld && r_addr >= r_n) begin
                    n_k        = r_n;
                    n_pend_vld = 1'b0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_pulse_ok) begin
                    n_addr  = r_k;
                    n_sidx  = '0;
                    n_state = S_SLICE;
                end else begin
                    n_res   = spnd_pkg::RES_NONE;
                    n_state = S_OUT;
                end
            end
            S_SLICE: begin
                if (r_sidx < spnd_pkg::SLICE_CW'(spnd_pkg::SLICE_KEEP)) begin
                    n_pend_vld = 1'b1;
                    n_pend_idx = spnd_pkg::CNT_W'(r_sidx);
                    n_addr     = r_addr + 1'b1;
                    n_sidx     = r_sidx + 1'b1;
                end
                if (r_pend_vld) begin
                    n_slice[r_pend_idx[spnd_pkg::SLICE_IW-1:0]] = (i_rdata > r_thr);
                end else if (r_sidx == spnd_pkg::SLICE_CW'(spnd_pkg::SLICE_KEEP)) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res   = w_chk;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld = 1'b1;
                    if (r_res >= 0) begin
                        n_out_data.sync_number = r_res[spnd_pkg::NUM_W-1:0];
                        n_out_data.status      = spnd_pkg::ST_VALID;
                    end else if (r_res == spnd_pkg::RES_NONE) begin
                        n_out_data.sync_number = '0;
                        n_out_data.status      = spnd_pkg::ST_NO_PULSE;
                    end else begin
                        n_out_data.sync_number = '0;
                        n_out_data.status      = spnd_pkg::ST_REJECTED;
                    end
                    n_prev  = r_res;
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_thr      <= n_thr;
        r_min      <= n_min;
        r_bank     <= n_bank;
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_k        <= n_k;
        r_sidx     <= n_sidx;
        r_slice    <= n_slice;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_prev     <= spnd_pkg::RES_NONE;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_prev     <= n_prev;
            r_out_vld  <= n_out_vld;
        end
    end

endmodule

[hw/rtl/sync_pulse_number_decoder.sv]
// Top level of the sync pulse number decoder: configuration, buffers and the two parts.
//
//   channel   direction  handshake               beat
//   in        input      i_in_valid / o_in_stall  t_in_beat: sample_word, last_sample
//   out       output     o_out_valid / i_out_stall t_out_beat: sync_number, status
//   cfg       input      i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// Samples are accepted one per cycle, while the input is not stalled, into one of two memory banks.
// After the last beat of a frame the back part scans up to the frame's n samples for the pulse,
// reads 54 more samples, decodes the number and waits for the output register.
// The input stalls only while both banks hold frames not yet passed to the output.
// Reset is synchronous; the sample memory is not cleared.
module sync_pulse_number_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  spnd_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output spnd_pkg::t_out_beat            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [spnd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spnd_pkg::SAMPLE_W-1:0]  i_cfg_wdata
);

    logic [spnd_pkg::SAMPLE_W-1:0] r_floor;
    logic [spnd_pkg::SAMPLE_W-1:0] r_swing;
    logic                          w_push;
    logic                          w_pop;
    logic                          w_full;
    logic                          w_empty;
    spnd_pkg::t_frame_desc         w_desc;
    spnd_pkg::t_frame_desc         w_head;
    spnd_pkg::t_mem_wr             w_mem_wr;
    logic [spnd_pkg::MEM_AW-1:0]   w_raddr;
    logic [spnd_pkg::SAMPLE_W-1:0] w_rdata;

    assign o_in_stall = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= spnd_pkg::FLOOR_RESET;
            r_swing <= spnd_pkg::SWING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spnd_pkg::CFG_FLOOR: r_floor <= i_cfg_wdata;
                spnd_pkg::CFG_SWING: r_swing <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    spnd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stall    (w_full),
        .i_in_data  (i_in_data),
        .i_floor    (r_floor),
        .o_push     (w_push),
        .o_desc     (w_desc),
        .o_mem_wr   (w_mem_wr)
    );

    spnd_ram #(
        .AW (spnd_pkg::MEM_AW),
        .DW (spnd_pkg::SAMPLE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_wr.we),
        .i_waddr (w_mem_wr.addr),
        .i_wdata (w_mem_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    spnd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    spnd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_empty   (w_empty),
        .o_pop       (w_pop),
        .i_min_swing (r_swing),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/spnd_checker.sv]
// Port-level checker for the sync pulse number decoder and its bind.
module spnd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input spnd_pkg::t_in_beat             i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input spnd_pkg::t_out_beat            o_out_data,
    input logic                           i_cfg_we,
    input logic [spnd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [spnd_pkg::SAMPLE_W-1:0]  i_cfg_wdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output beat valid right after reset.");

    a_number_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != spnd_pkg::ST_VALID)
            |-> (o_out_data.sync_number == '0))
        else $error("Nonzero number on a failed frame.");

    a_stall_needs_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall && i_in_data.last_sample))
        else $error("Input stall rose without a frame ending.");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("Output beat dropped while stalled.");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("Output beat changed while stalled.");

endmodule

bind sync_pulse_number_decoder spnd_checker u_spnd_checker (.*);
